[hw/rtl/lkvc_pkg.sv]
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

	// Field widths of one request and one response.
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	// Capacity after reset, before it is clamped to the number of slots.
	localparam int CAPACITY_RESET = 16;

	// Read value returned on a lookup miss.
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// Request kinds carried in the slave-side tuser.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_RESULT
	} lkvc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic lookup;
		logic update;
		logic load_out;
	} lkvc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_put;
	} lkvc_stat_t;

endpackage

[hw/rtl/lru_key_value_cache_unit.sv]
// Top level of the LRU key/value cache: stream ports, configuration port, controller and datapath.
// A put passes through the accept, compare and update states before the next request can be accepted.
// A get then enters a result state that loads its response into the output register behind m_tvalid;
// the next request is taken after it; a stalled response holds the controller in its result state.
// These steps are set by the parallel key compare, the rank update and the value memory read port.
// Reset empties the store and sets capacity to 16 clamped to ENTRIES; a capacity write empties it too.
module lru_key_value_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: capacity.
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	// Requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // [31:0] key, [63:32] value
	input  logic [0:0]  s_tuser,    // [0] op
	// Responses.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] read_value
	output logic [0:0]  m_tuser     // [0] hit
);

	lkvc_pkg::lkvc_cmd_t                cmd;
	lkvc_pkg::lkvc_stat_t               status;
	logic signed [lkvc_pkg::VAL_W-1:0]  out_value;
	logic                               out_hit;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lkvc_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_op       (s_tuser[0]),
		.in_key      ($signed(s_tdata[31:0])),
		.in_value    ($signed(s_tdata[63:32])),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_hit     (out_hit),
		.out_value   (out_value)
	);

	assign m_tdata = out_value;
	assign m_tuser = out_hit;

endmodule

[hw/rtl/lkvc_ctrl.sv]
// Controller state machine that sequences lookup, update and response of each transaction.
module lkvc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  lkvc_pkg::lkvc_stat_t  status,
	output lkvc_pkg::lkvc_cmd_t   cmd
);

	lkvc_pkg::lkvc_state_t state_q;
	lkvc_pkg::lkvc_state_t state_d;
	logic                  out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = lkvc_pkg::ST_LOOKUP;
				end
			end
			lkvc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = lkvc_pkg::ST_UPDATE;
			end
			lkvc_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = status.is_put ? lkvc_pkg::ST_IDLE : lkvc_pkg::ST_RESULT;
			end
			lkvc_pkg::ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = lkvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	// Output register occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	// A response is only loaded into a free or draining output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("response loaded over a pending transaction");

	// A blocked response holds the controller in the result state.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkvc_pkg::ST_RESULT && out_valid_q && !m_tready)
		|=> state_q == lkvc_pkg::ST_RESULT)
		else $error("result state left while output stalled");

	// An accepted request always starts a lookup.
	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == lkvc_pkg::ST_LOOKUP)
		else $error("accepted request did not start a lookup");

endmodule

[hw/rtl/lkvc_datapath.sv]
// Datapath: request registers, key compare lanes, recency ranks, value memory and response register.
module lkvc_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lkvc_pkg::lkvc_cmd_t                 cmd,
	output lkvc_pkg::lkvc_stat_t                status,
	input  logic                                in_op,
	input  logic signed [lkvc_pkg::KEY_W-1:0]   in_key,
	input  logic signed [lkvc_pkg::VAL_W-1:0]   in_value,
	input  logic                                cfg_wr_en,
	input  logic        [lkvc_pkg::CAP_W-1:0]   cfg_wr_data,
	output logic                                out_hit,
	output logic signed [lkvc_pkg::VAL_W-1:0]   out_value
);

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CMP_W   = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
	localparam int CAP_RST = (lkvc_pkg::CAPACITY_RESET > ENTRIES) ? ENTRIES
		: lkvc_pkg::CAPACITY_RESET;

	// Request registers.
	logic                          req_op_q;
	logic [lkvc_pkg::KEY_W-1:0]    req_key_q;
	logic [lkvc_pkg::VAL_W-1:0]    req_value_q;

	// Slot state.
	logic [lkvc_pkg::KEY_W-1:0]    tag_q  [ENTRIES];
	logic [RANK_W-1:0]             rank_q [ENTRIES];
	logic [ENTRIES-1:0]            valid_q;
	logic [OCC_W-1:0]              occ_q;
	logic [OCC_W-1:0]              cap_eff_q;
	logic [OCC_W-1:0]              cap_eff_d;

	// Value memory.
	logic [lkvc_pkg::VAL_W-1:0]    val_mem [ENTRIES];
	logic [lkvc_pkg::VAL_W-1:0]    mem_rd_q;

	// Lookup stage results.
	logic [ENTRIES-1:0]            match_vec;
	logic [ENTRIES-1:0]            victim_vec;
	logic [ENTRIES-1:0]            free_vec;
	logic [ENTRIES-1:0]            invalid_vec;
	logic [RANK_W-1:0]             oldest_rank;
	logic [ENTRIES-1:0]            hit_vec_s1;
	logic [ENTRIES-1:0]            victim_vec_s1;
	logic [ENTRIES-1:0]            free_vec_s1;
	logic                          hit_s1;
	logic                          full_s1;

	// Update stage signals.
	logic [ENTRIES-1:0]            tgt_vec;
	logic [IDX_W-1:0]              tgt_idx;
	logic [RANK_W-1:0]             hit_rank;
	logic                          insert_en;
	logic                          touch_en;
	logic                          mem_we;
	logic                          hit_s2;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_op_q    <= in_op;
			req_key_q   <= in_key;
			req_value_q <= in_value;
		end
	end

	assign status.is_put = (req_op_q == lkvc_pkg::OP_PUT);

	// Parallel key compare, eviction candidate and first free slot.
	assign oldest_rank = RANK_W'(occ_q - OCC_W'(1));
	assign invalid_vec = ~valid_q;
	assign free_vec    = invalid_vec & (~invalid_vec + ENTRIES'(1));
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i]  = valid_q[i] && (tag_q[i] == req_key_q);
			victim_vec[i] = valid_q[i] && (rank_q[i] == oldest_rank);
		end
	end

	// Lookup stage register.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_vec_s1    <= match_vec;
			victim_vec_s1 <= victim_vec;
			free_vec_s1   <= free_vec;
			hit_s1        <= |match_vec;
			full_s1       <= (occ_q >= cap_eff_q);
		end
	end

	// Target slot selection, its index and the rank of a hit slot.
	assign tgt_vec = hit_s1 ? hit_vec_s1 : (full_s1 ? victim_vec_s1 : free_vec_s1);
	always_comb begin
		tgt_idx  = '0;
		hit_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tgt_idx  = tgt_idx | (tgt_vec[i] ? IDX_W'(i) : '0);
			hit_rank = hit_rank | (hit_vec_s1[i] ? rank_q[i] : '0);
		end
	end

	assign insert_en = cmd.update && status.is_put && !hit_s1;
	assign touch_en  = cmd.update && (hit_s1 || status.is_put);
	assign mem_we    = cmd.update && status.is_put;

	// Capacity clamped to the range one to the number of slots.
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_eff_d = OCC_W'(1);
		end else if (CMP_W'(cfg_wr_data) > CMP_W'(ENTRIES)) begin
			cap_eff_d = OCC_W'(ENTRIES);
		end else begin
			cap_eff_d = OCC_W'(cfg_wr_data);
		end
	end

	// Capacity, occupancy, valid bits and recency ranks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_eff_q <= OCC_W'(CAP_RST);
			occ_q     <= '0;
			valid_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			cap_eff_q <= cap_eff_d;
			occ_q     <= '0;
			valid_q   <= '0;
		end else if (touch_en) begin
			if (insert_en && !full_s1) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (tgt_vec[i]) begin
					rank_q[i]  <= '0;
					valid_q[i] <= 1'b1;
				end else if (valid_q[i] && (!hit_s1 || rank_q[i] < hit_rank)) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
		end
	end

	// Key lanes are written only on insertion.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (insert_en && tgt_vec[i]) begin
				tag_q[i] <= req_key_q;
			end
		end
	end

	// Value memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			val_mem[tgt_idx] <= req_value_q;
		end
		mem_rd_q <= val_mem[tgt_idx];
	end

	// Hit flag travels alongside the memory read.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_s2 <= hit_s1;
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit   <= hit_s2;
			out_value <= hit_s2 ? mem_rd_q : lkvc_pkg::MISS_VALUE;
		end
	end

	// Occupancy never exceeds the configured capacity.
	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_eff_q)
		else $error("occupancy above capacity");

	// Occupancy counts the valid slots.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == occ_q)
		else $error("occupancy and valid bits disagree");

	// Keys are unique, so at most one lane matches.
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |-> $onehot0(match_vec))
		else $error("key present in more than one slot");

endmodule

[test/tb_lru_key_value_cache_unit.sv]
// Testbench for the LRU key/value cache: random and directed requests checked against a predictor.
module tb_lru_key_value_cache_unit;

	localparam int SLOTS = 16;

	// One expected lookup response.
	typedef struct packed {
		logic                       hit;
		logic [lkvc_pkg::VAL_W-1:0] read_value;
	} lookup_result_t;

	// Predicts lookup responses from accepted requests and checks the actual responses.
	class lru_cache_scoreboard_t;
		logic [lkvc_pkg::KEY_W-1:0] slot_key[SLOTS];
		logic [lkvc_pkg::VAL_W-1:0] slot_value[SLOTS];
		bit                         slot_valid[SLOTS];
		int unsigned                slot_rank[SLOTS];
		int unsigned                occupancy;
		int unsigned                capacity;
		lookup_result_t             pending_lookups[$];
		int unsigned                mismatches;

		function new();
			capacity = lkvc_pkg::CAPACITY_RESET;
			mismatches = 0;
			empty_store();
		endfunction

		function void empty_store();
			for (int i = 0; i < SLOTS; i++) begin
				slot_key[i] = '0;
				slot_value[i] = '0;
				slot_valid[i] = 1'b0;
				slot_rank[i] = 0;
			end
			occupancy = 0;
		endfunction

		// A capacity write always empties the store, even when the value is unchanged.
		function void set_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
			capacity = c;
			empty_store();
		endfunction

		// Every valid slot more recent than slot s ages by one; s becomes the most recent.
		function void make_recent(int s);
			int unsigned r;
			r = slot_rank[s];
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && i != s && slot_rank[i] < r)
					slot_rank[i]++;
			slot_rank[s] = 0;
		endfunction

		// Apply one accepted request; a lookup queues its expected response.
		function void note_request(logic op, logic [lkvc_pkg::KEY_W-1:0] key,
			logic [lkvc_pkg::VAL_W-1:0] value);
			int             s;
			int unsigned    limit;
			int unsigned    oldest;
			lookup_result_t res;
			s = -1;
			for (int i = 0; i < SLOTS; i++)
				if (s < 0 && slot_valid[i] && slot_key[i] == key)
					s = i;
			if (op == lkvc_pkg::OP_GET) begin
				if (s >= 0) begin
					make_recent(s);
					res.hit = 1'b1;
					res.read_value = slot_value[s];
				end else begin
					res.hit = 1'b0;
					res.read_value = lkvc_pkg::MISS_VALUE;
				end
				pending_lookups.insert(pending_lookups.size(), res);
			end else if (s >= 0) begin
				slot_value[s] = value;
				make_recent(s);
			end else begin
				// Capacity zero acts as one; anything above the slot count saturates.
				limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
				if (occupancy >= limit) begin
					// Reuse the least recent slot; the first one wins a tie.
					oldest = 0;
					for (int i = 0; i < SLOTS; i++)
						if (slot_valid[i] && (s < 0 || slot_rank[i] > oldest)) begin
							s = i;
							oldest = slot_rank[i];
						end
				end else begin
					// Fill the lowest-numbered free slot.
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!slot_valid[i])
							s = i;
					slot_valid[s] = 1'b1;
					slot_rank[s] = occupancy;
					occupancy++;
				end
				slot_key[s] = key;
				slot_value[s] = value;
				make_recent(s);
			end
		endfunction

		// Compare one response transaction with the oldest expected lookup.
		function void check_response(logic hit, logic [lkvc_pkg::VAL_W-1:0] read_value);
			lookup_result_t exp_res;
			if (pending_lookups.size() == 0) begin
				$display("%0t unexpected response: hit %0b read_value %h", $time, hit, read_value);
				mismatches++;
				return;
			end
			exp_res = pending_lookups[0];
			pending_lookups.delete(0);
			if (hit !== exp_res.hit) begin
				$display("%0t hit mismatch: expected %0b actual %0b", $time, exp_res.hit, hit);
				mismatches++;
			end
			if (read_value !== exp_res.read_value) begin
				$display("%0t read_value mismatch: expected %h actual %h",
					$time, exp_res.read_value, read_value);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [63:0]                s_tdata;
	logic [0:0]                 s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [31:0]                m_tdata;
	logic [0:0]                 m_tuser;

	lru_cache_scoreboard_t cache_sb;
	bit                    steady;
	bit                    hold_request;

	lru_key_value_cache_unit #(.ENTRIES(SLOTS)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// Clock with a period of 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one request and wait until its transaction is accepted.
	task automatic send_request(input logic op, input logic [lkvc_pkg::KEY_W-1:0] key,
		input logic [lkvc_pkg::VAL_W-1:0] value);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {value, key};
		do
			@(posedge clk);
		while (!s_tready);
		cache_sb.note_request(op, key, value);
	endtask

	// Write capacity once the block has gone quiet.
	task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cache_sb.pending_lookups.size() != 0)
			@(posedge clk);
		// A trailing put may still be updating the store.
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cache_sb.set_capacity(c);
	endtask

	// Random traffic over a small key pool so that hits, updates and evictions occur.
	task automatic random_phase(input int n_items);
		logic [lkvc_pkg::KEY_W-1:0] key_pool[];
		logic [lkvc_pkg::KEY_W-1:0] key;
		logic [lkvc_pkg::VAL_W-1:0] value;
		logic                       op;
		int unsigned                pick;
		key_pool = new[$urandom_range(3, SLOTS + 3)];
		foreach (key_pool[i]) begin
			pick = $urandom_range(9);
			if (pick == 0)
				key_pool[i] = 32'h8000_0000;
			else if (pick == 1)
				key_pool[i] = 32'h7FFF_FFFF;
			else
				key_pool[i] = $urandom;
		end
		for (int n = 0; n < n_items; n++) begin
			op = ($urandom_range(1) == 0) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_PUT;
			if ($urandom_range(9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(key_pool.size() - 1)];
			pick = $urandom_range(15);
			value = (pick == 0) ? '0 : ((pick == 1) ? '1 : $urandom);
			send_request(op, key, value);
		end
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (150) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 19);
			end
		end
	end

	// Check every response transaction.
	always @(posedge clk)
		if (m_tvalid && m_tready)
			cache_sb.check_response(m_tuser[0], m_tdata);

	// Stimulus and end of run.
	initial begin
		cache_sb = new();
		steady = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lkvc_pkg::OP_GET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty store after reset, key and value extremes, update in place.
		send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
		send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

		// Two entries: a lookup refreshes one, so the other is evicted.
		write_capacity(5'd2);
		send_request(lkvc_pkg::OP_PUT, 32'h0000_0011, 32'hAAAA_0001);
		send_request(lkvc_pkg::OP_PUT, 32'h0000_0022, 32'hAAAA_0002);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0011, 32'h0000_0000);
		send_request(lkvc_pkg::OP_PUT, 32'h0000_0033, 32'hAAAA_0003);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0022, 32'h0000_0000);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0011, 32'h0000_0000);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0033, 32'h0000_0000);

		// Writing the same capacity again still empties the store.
		write_capacity(5'd2);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0011, 32'h0000_0000);

		// Capacity zero keeps a single entry.
		write_capacity(5'd0);
		send_request(lkvc_pkg::OP_PUT, 32'h0000_0044, 32'h5555_0004);
		send_request(lkvc_pkg::OP_PUT, 32'h0000_0055, 32'h5555_0005);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0044, 32'h0000_0000);
		send_request(lkvc_pkg::OP_GET, 32'h0000_0055, 32'h0000_0000);

		// Random phases over several capacities, extremes included.
		write_capacity(5'd3);
		random_phase(50);
		write_capacity(5'd31);
		random_phase(50);
		write_capacity(5'd1);
		steady = 1'b1;
		random_phase(50);
		steady = 1'b0;
		write_capacity(5'd5);
		hold_request = 1'b1;
		random_phase(50);
		write_capacity(5'd17);
		random_phase(50);
		write_capacity(5'd16);
		random_phase(50);
		write_capacity(5'd0);
		random_phase(50);
		write_capacity(5'd8);
		random_phase(50);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cache_sb.pending_lookups.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (cache_sb.mismatches == 0 && cache_sb.pending_lookups.size() == 0) begin
			$display("PASS lru_key_value_cache_unit");
		end else begin
			$display("FAIL lru_key_value_cache_unit");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#1000000;
		$display("FAIL lru_key_value_cache_unit");
		$finish;
	end

endmodule

[files.f]
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_datapath.sv
hw/rtl/lru_key_value_cache_unit.sv
test/tb_lru_key_value_cache_unit.sv
